[rtl/lph_pkg.sv]
// ----------------------------------------------------------------------------
// lph_pkg
// Shared request codes, status codes and cell handshake types for the
// linear-probe hash table.
// ----------------------------------------------------------------------------
package lph_pkg;

	localparam int KEY_W    = 32;
	localparam int KIND_W   = 2;
	localparam int SLOT_W   = 4;
	localparam int STATUS_W = 2;

	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
	localparam logic [STATUS_W-1:0] ST_ZERO_KEY  = 2'd3;

	// probe token control, handed from cell to cell
	typedef struct packed {
		logic vld;
		logic ins;
		logic del;
	} tok_ctrl_t;

	// result raised by the cell that finishes a transaction
	typedef struct packed {
		logic                vld;
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot;
	} res_t;

endpackage

[rtl/lph_home.sv]
// ----------------------------------------------------------------------------
// lph_home
// Home slot unit: key modulo table size. A power-of-two size takes the low
// key bits; any other size reduces the key one nibble per cycle.
// ----------------------------------------------------------------------------
module lph_home #(
	parameter int TABLE_SIZE = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [lph_pkg::KEY_W-1:0]   key,
	output logic                        done,
	output logic [$clog2(TABLE_SIZE)-1:0] home
);

	localparam int  IW     = $clog2(TABLE_SIZE);
	localparam bit  IS_POW2 = ((TABLE_SIZE & (TABLE_SIZE - 1)) == 0);
	localparam int  NIBS   = lph_pkg::KEY_W / 4;
	localparam int  NW     = $clog2(NIBS);

	logic          done_q;
	logic [IW-1:0] rem_q;

	assign done = done_q;
	assign home = rem_q;

	if (IS_POW2) begin : g_pow2
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				done_q <= 1'b0;
			end else begin
				done_q <= start;
			end
		end

		always_ff @(posedge clk) begin
			if (start) begin
				rem_q <= key[IW-1:0];
			end
		end
	end else begin : g_serial
		logic                      busy_q;
		logic [NW-1:0]             cnt_q;
		logic [lph_pkg::KEY_W-1:0] sh_q;
		logic [IW+3:0]             acc;
		logic [IW-1:0]             rem_n;

		assign acc = {rem_q, sh_q[lph_pkg::KEY_W-1 -: 4]};

		// acc stays below sixteen times the table size
		always_comb begin
			int kn;
			rem_n = acc[IW-1:0];
			for (int k = 1; k < 16; k++) begin
				kn = k * TABLE_SIZE;
				if (int'(acc) >= kn) begin
					rem_n = IW'(int'(acc) - kn);
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				busy_q <= 1'b0;
				done_q <= 1'b0;
				cnt_q  <= '0;
			end else begin
				done_q <= busy_q && (cnt_q == NW'(NIBS - 1));
				if (start) begin
					busy_q <= 1'b1;
					cnt_q  <= '0;
				end else if (busy_q) begin
					cnt_q <= cnt_q + NW'(1);
					if (cnt_q == NW'(NIBS - 1)) begin
						busy_q <= 1'b0;
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (start) begin
				sh_q  <= key;
				rem_q <= '0;
			end else if (busy_q) begin
				sh_q  <= {sh_q[lph_pkg::KEY_W-5:0], 4'b0000};
				rem_q <= rem_n;
			end
		end
	end

endmodule

[rtl/lph_cell.sv]
// ----------------------------------------------------------------------------
// lph_cell
// One table slot. Takes the probe token from the previous cell, stores,
// matches or clears its key, and either finishes the transaction or hands
// the token on.
// ----------------------------------------------------------------------------
module lph_cell #(
	parameter int TABLE_SIZE = 16,
	parameter int IDX        = 0
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lph_pkg::tok_ctrl_t                  in_ctrl,
	input  logic [lph_pkg::KEY_W-1:0]           in_key,
	input  logic [$clog2(TABLE_SIZE+1)-1:0]     in_left,
	output lph_pkg::tok_ctrl_t                  out_ctrl,
	output logic [lph_pkg::KEY_W-1:0]           out_key,
	output logic [$clog2(TABLE_SIZE+1)-1:0]     out_left,
	output lph_pkg::res_t                       res
);

	localparam int CW = $clog2(TABLE_SIZE + 1);

	logic [lph_pkg::KEY_W-1:0] slot_q;
	logic [lph_pkg::KEY_W-1:0] slot_n;
	lph_pkg::tok_ctrl_t        ctrl_q;
	lph_pkg::tok_ctrl_t        ctrl_n;
	lph_pkg::res_t             res_q;
	lph_pkg::res_t             res_n;
	logic [lph_pkg::KEY_W-1:0] key_q;
	logic [CW-1:0]             left_q;
	logic                      last;

	assign last = (in_left == CW'(1));

	always_comb begin
		slot_n = slot_q;
		ctrl_n = '0;
		res_n  = '0;
		if (in_ctrl.vld) begin
			if (in_ctrl.ins) begin
				if (slot_q == '0) begin
					slot_n = in_key;
					res_n  = '{vld: 1'b1, status: lph_pkg::ST_OK,
						slot: lph_pkg::SLOT_W'(IDX)};
				end else if (last) begin
					res_n = '{vld: 1'b1, status: lph_pkg::ST_FULL, slot: '0};
				end else begin
					ctrl_n = in_ctrl;
				end
			end else begin
				if (slot_q == in_key) begin
					if (in_ctrl.del) begin
						slot_n = '0;
					end
					res_n = '{vld: 1'b1, status: lph_pkg::ST_OK,
						slot: lph_pkg::SLOT_W'(IDX)};
				end else if (last) begin
					res_n = '{vld: 1'b1, status: lph_pkg::ST_NOT_FOUND, slot: '0};
				end else begin
					ctrl_n = in_ctrl;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			ctrl_q <= '0;
			res_q  <= '0;
		end else begin
			slot_q <= slot_n;
			ctrl_q <= ctrl_n;
			res_q  <= res_n;
		end
	end

	always_ff @(posedge clk) begin
		key_q  <= in_key;
		left_q <= in_left - CW'(1);
	end

	assign out_ctrl = ctrl_q;
	assign out_key  = key_q;
	assign out_left = left_q;
	assign res      = res_q;

endmodule

[rtl/linear_probe_hash_table_core.sv]
// A zero key result is registered straight into the output stage. Any other
// request sends a token round the ring from the home slot for an insert, else
// slot 0, until a cell finishes it; sizes other than a power of two first
// reduce the home slot nibble-serially. One transaction at a time: the next is
// accepted once the result registers, unless it has to wait in the skid entry.
// reset: asynchronous, all slots empty, no transaction pending.
// ----------------------------------------------------------------------------
// linear_probe_hash_table_core
// Open-addressing hash table with linear probing, built as a ring of slot
// cells through which a probe token travels one cell per cycle.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_core #(
	parameter int TABLE_SIZE = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [lph_pkg::KIND_W-1:0]      kind,
	input  logic [lph_pkg::KEY_W-1:0]       key,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [lph_pkg::SLOT_W-1:0]      slot,
	output logic [lph_pkg::STATUS_W-1:0]    status
);

	localparam int IW = $clog2(TABLE_SIZE);
	localparam int CW = $clog2(TABLE_SIZE + 1);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_HOME = 3'b010,
		S_RUN  = 3'b100
	} state_t;

	state_t                    state_q;
	logic                      ins_q;
	logic                      del_q;
	logic [lph_pkg::KEY_W-1:0] key_q;

	logic                      in_fire;
	logic                      home_start;
	logic                      home_done;
	logic [IW-1:0]             home;

	lph_pkg::tok_ctrl_t        inj_ctrl;
	logic [IW-1:0]             inj_at;

	lph_pkg::tok_ctrl_t        cin_ctrl  [TABLE_SIZE];
	logic [lph_pkg::KEY_W-1:0] cin_key   [TABLE_SIZE];
	logic [CW-1:0]             cin_left  [TABLE_SIZE];
	lph_pkg::tok_ctrl_t        cout_ctrl [TABLE_SIZE];
	logic [lph_pkg::KEY_W-1:0] cout_key  [TABLE_SIZE];
	logic [CW-1:0]             cout_left [TABLE_SIZE];
	lph_pkg::res_t             cres      [TABLE_SIZE];
	lph_pkg::res_t             res_any;
	lph_pkg::res_t             fin;

	logic                          out_vld_q;
	logic [lph_pkg::SLOT_W-1:0]    out_slot_q;
	logic [lph_pkg::STATUS_W-1:0]  out_status_q;
	logic                          pend_vld_q;
	logic [lph_pkg::SLOT_W-1:0]    pend_slot_q;
	logic [lph_pkg::STATUS_W-1:0]  pend_status_q;
	logic                          out_free;

	assign in_ready   = (state_q == S_IDLE) && !pend_vld_q;
	assign in_fire    = in_valid && in_ready;
	assign home_start = in_fire && (key != '0);

	lph_home #(
		.TABLE_SIZE(TABLE_SIZE)
	) u_home (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (home_start),
		.key    (key),
		.done   (home_done),
		.home   (home)
	);

	// token injection once the home slot is known
	always_comb begin
		inj_ctrl     = '0;
		inj_ctrl.vld = (state_q == S_HOME) && home_done;
		inj_ctrl.ins = ins_q;
		inj_ctrl.del = del_q;
		inj_at       = ins_q ? home : '0;
	end

	for (genvar i = 0; i < TABLE_SIZE; i++) begin : g_cell
		localparam int PREV = (i + TABLE_SIZE - 1) % TABLE_SIZE;

		always_comb begin
			if (inj_ctrl.vld && (inj_at == IW'(i))) begin
				cin_ctrl[i] = inj_ctrl;
				cin_key[i]  = key_q;
				cin_left[i] = CW'(TABLE_SIZE);
			end else begin
				cin_ctrl[i] = cout_ctrl[PREV];
				cin_key[i]  = cout_key[PREV];
				cin_left[i] = cout_left[PREV];
			end
		end

		lph_cell #(
			.TABLE_SIZE(TABLE_SIZE),
			.IDX       (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_ctrl  (cin_ctrl[i]),
			.in_key   (cin_key[i]),
			.in_left  (cin_left[i]),
			.out_ctrl (cout_ctrl[i]),
			.out_key  (cout_key[i]),
			.out_left (cout_left[i]),
			.res      (cres[i])
		);
	end

	// at most one cell finishes in a cycle
	always_comb begin
		res_any = '0;
		for (int i = 0; i < TABLE_SIZE; i++) begin
			res_any = res_any | cres[i];
		end
	end

	always_comb begin
		fin = '0;
		if (in_fire && (key == '0)) begin
			fin = '{vld: 1'b1, status: lph_pkg::ST_ZERO_KEY, slot: '0};
		end else if (state_q == S_RUN) begin
			fin = res_any;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (home_start) begin
						state_q <= S_HOME;
					end
				end
				S_HOME: begin
					if (home_done) begin
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					if (res_any.vld) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			ins_q <= (kind == lph_pkg::KIND_INSERT);
			del_q <= (kind == lph_pkg::KIND_DELETE);
			key_q <= key;
		end
	end

	// output register with one skid entry
	assign out_free = !out_vld_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			pend_vld_q <= 1'b0;
		end else begin
			if (fin.vld) begin
				if (out_free) begin
					out_vld_q <= 1'b1;
				end else begin
					pend_vld_q <= 1'b1;
				end
			end else if (out_free) begin
				out_vld_q  <= pend_vld_q;
				pend_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin.vld) begin
			if (out_free) begin
				out_slot_q   <= fin.slot;
				out_status_q <= fin.status;
			end else begin
				pend_slot_q   <= fin.slot;
				pend_status_q <= fin.status;
			end
		end else if (out_free && pend_vld_q) begin
			out_slot_q   <= pend_slot_q;
			out_status_q <= pend_status_q;
		end
	end

	assign out_valid = out_vld_q;
	assign slot      = out_slot_q;
	assign status    = out_status_q;

endmodule

[tb/tb_linear_probe_hash_table_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_linear_probe_hash_table_core
// Self-checking bench for the linear-probe hash table. A directed table covers
// zero keys, the widest key, collisions, duplicates, the unused kind and a full
// table. Random traffic then alternates insert-heavy and delete-heavy stretches
// under three idle profiles. Each result is checked against its typed row or a local model.
// ----------------------------------------------------------------------------
module tb_linear_probe_hash_table_core;

	localparam int TABLE_SIZE     = 16;
	localparam int CLK_HALF       = 6;
	localparam int NUM_DIRECTED   = 25;
	localparam int RAND_PER_PHASE = 550;
	localparam int NUM_PHASES     = 3;
	localparam int DRAIN_CYCLES   = TABLE_SIZE + 16;
	localparam int CYCLE_LIMIT    = 400000;

	localparam logic [lph_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

	typedef struct packed {
		logic [lph_pkg::SLOT_W-1:0]   slot;
		logic [lph_pkg::STATUS_W-1:0] status;
	} table_res_t;

	typedef struct packed {
		logic [lph_pkg::KIND_W-1:0]   kind;
		logic [lph_pkg::KEY_W-1:0]    key;
		logic                         typed;
		logic [lph_pkg::SLOT_W-1:0]   slot;
		logic [lph_pkg::STATUS_W-1:0] status;
	} dir_row_t;

	localparam dir_row_t DIR_ROWS [NUM_DIRECTED] = '{
		'{lph_pkg::KIND_SEARCH, 32'h0000_0005, 1'b1, 4'd0,  lph_pkg::ST_NOT_FOUND},
		'{lph_pkg::KIND_INSERT, 32'h0000_0000, 1'b1, 4'd0,  lph_pkg::ST_ZERO_KEY},
		'{lph_pkg::KIND_DELETE, 32'h0000_0000, 1'b1, 4'd0,  lph_pkg::ST_ZERO_KEY},
		'{KIND_UNUSED,          32'h0000_0000, 1'b1, 4'd0,  lph_pkg::ST_ZERO_KEY},
		'{lph_pkg::KIND_INSERT, 32'hFFFF_FFFF, 1'b1, 4'd15, lph_pkg::ST_OK},
		'{lph_pkg::KIND_INSERT, 32'h0000_0001, 1'b1, 4'd1,  lph_pkg::ST_OK},
		'{lph_pkg::KIND_INSERT, 32'h0000_0011, 1'b0, 4'd0,  lph_pkg::ST_OK},
		'{lph_pkg::KIND_INSERT, 32'h0000_0001, 1'b0, 4'd0,  lph_pkg::ST_OK},
		'{lph_pkg::KIND_SEARCH, 32'h0000_0011, 1'b0, 4'd0,  lph_pkg::ST_OK},
		'{lph_pkg::KIND_DELETE, 32'h0000_0001, 1'b0, 4'd0,  lph_pkg::ST_OK},
		'{KIND_UNUSED,          32'h0000_0001, 1'b0, 4'd0,  lph_pkg::ST_OK},
		'{lph_pkg::KIND_INSERT, 32'h8000_0000, 1'b0, 4'd0,  lph_pkg::ST_OK},
		'{lph_pkg::KIND_INSERT, 32'h7FFF_FFF0, 1'b0, 4'd0,  lph_pkg::ST_OK},
		'{lph_pkg::KIND_INSERT, 32'h0000_0010, 1'b0, 4'd0,  lph_pkg::ST_OK},
		'{lph_pkg::KIND_INSERT, 32'h0000_0020, 1'b0, 4'd0,  lph_pkg::ST_OK},
		'{lph_pkg::KIND_INSERT, 32'h0000_0030, 1'b0, 4'd0,  lph_pkg::ST_OK},
		'{lph_pkg::KIND_INSERT, 32'h0000_0040, 1'b0, 4'd0,  lph_pkg::ST_OK},
		'{lph_pkg::KIND_INSERT, 32'h0000_0050, 1'b0, 4'd0,  lph_pkg::ST_OK},
		'{lph_pkg::KIND_INSERT, 32'h0000_0060, 1'b0, 4'd0,  lph_pkg::ST_OK},
		'{lph_pkg::KIND_INSERT, 32'h0000_0070, 1'b0, 4'd0,  lph_pkg::ST_OK},
		'{lph_pkg::KIND_INSERT, 32'h0000_0090, 1'b0, 4'd0,  lph_pkg::ST_OK},
		'{lph_pkg::KIND_INSERT, 32'h0000_00A0, 1'b0, 4'd0,  lph_pkg::ST_OK},
		'{lph_pkg::KIND_INSERT, 32'h0000_00B0, 1'b0, 4'd0,  lph_pkg::ST_OK},
		'{lph_pkg::KIND_INSERT, 32'h0000_00C0, 1'b0, 4'd0,  lph_pkg::ST_OK},
		'{lph_pkg::KIND_INSERT, 32'hFFFF_FFFE, 1'b1, 4'd0,  lph_pkg::ST_FULL}
	};

	localparam int SND_IDLE [NUM_PHASES] = '{23, 84, 0};
	localparam int RCV_IDLE [NUM_PHASES] = '{84, 23, 0};

	logic                         clk       = 1'b0;
	logic                         arst_n    = 1'b0;
	logic                         in_valid  = 1'b0;
	logic                         in_ready;
	logic [lph_pkg::KIND_W-1:0]   kind      = '0;
	logic [lph_pkg::KEY_W-1:0]    key       = '0;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	logic [lph_pkg::SLOT_W-1:0]   slot;
	logic [lph_pkg::STATUS_W-1:0] status;

	logic [lph_pkg::KEY_W-1:0] slot_keys [TABLE_SIZE];
	table_res_t                pending_results [$];
	int                        fail_count  = 0;
	int                        cycle_count = 0;
	int                        snd_idle    = SND_IDLE[0];
	int                        rcv_idle    = RCV_IDLE[0];

	linear_probe_hash_table_core #(
		.TABLE_SIZE(TABLE_SIZE)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.kind     (kind),
		.key      (key),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.slot     (slot),
		.status   (status)
	);

	always #CLK_HALF clk = ~clk;

	// applies one request to the local table and returns its result
	function automatic table_res_t hash_table_apply(input logic [lph_pkg::KIND_W-1:0] k_in,
			input logic [lph_pkg::KEY_W-1:0] key_in);
		table_res_t  r;
		int unsigned home;
		int unsigned at;
		bit          hit;
		r.slot   = '0;
		r.status = lph_pkg::ST_NOT_FOUND;
		hit      = 1'b0;
		if (key_in == '0) begin
			r.status = lph_pkg::ST_ZERO_KEY;
		end else if (k_in == lph_pkg::KIND_INSERT) begin
			r.status = lph_pkg::ST_FULL;
			home     = key_in % 32'(TABLE_SIZE);
			for (int i = 0; i < TABLE_SIZE && !hit; i++) begin
				at = (home + i) % TABLE_SIZE;
				if (slot_keys[at] == '0) begin
					slot_keys[at] = key_in;
					r.slot        = lph_pkg::SLOT_W'(at);
					r.status      = lph_pkg::ST_OK;
					hit           = 1'b1;
				end
			end
		end else begin
			for (int i = 0; i < TABLE_SIZE && !hit; i++) begin
				if (slot_keys[i] == key_in) begin
					r.slot   = lph_pkg::SLOT_W'(i);
					r.status = lph_pkg::ST_OK;
					hit      = 1'b1;
					if (k_in == lph_pkg::KIND_DELETE) slot_keys[i] = '0;
				end
			end
		end
		return r;
	endfunction

	// mostly keys already stored or with crowded home slots, some zero, some wide
	function automatic logic [lph_pkg::KEY_W-1:0] pick_key();
		int unsigned               r;
		logic [lph_pkg::KEY_W-1:0] k;
		r = $urandom_range(99);
		k = $urandom;
		if (r < 4) begin
			k = '0;
		end else if (r < 50) begin
			k = slot_keys[$urandom_range(TABLE_SIZE - 1)];
			if (k == '0) k = lph_pkg::KEY_W'($urandom_range(64, 1));
		end else if (r < 75) begin
			k = lph_pkg::KEY_W'($urandom_range(64, 1));
		end
		return k;
	endfunction

	function automatic logic [lph_pkg::KIND_W-1:0] pick_kind(input int ins_pct);
		int unsigned r;
		r = $urandom_range(99);
		if (r < ins_pct) return lph_pkg::KIND_INSERT;
		if (r < ins_pct + (100 - ins_pct) / 2) return lph_pkg::KIND_DELETE;
		if (r < 95) return lph_pkg::KIND_SEARCH;
		return KIND_UNUSED;
	endfunction

	task automatic issue_request(input logic [lph_pkg::KIND_W-1:0] k_in,
			input logic [lph_pkg::KEY_W-1:0] key_in,
			input logic typed, input table_res_t typed_res);
		table_res_t r;
		while ($urandom_range(99) < snd_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind     <= k_in;
		key      <= key_in;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		r = hash_table_apply(k_in, key_in);
		pending_results.push_back(typed ? typed_res : r);
	endtask

	task automatic hold_until_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		table_res_t exp_res;
		if (out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				fail_count++;
				$display("%0t: unexpected transaction, expected none, actual slot %0d status %0d",
					$time, slot, status);
			end else begin
				exp_res = pending_results.pop_front();
				if (slot !== exp_res.slot) begin
					fail_count++;
					$display("%0t: slot mismatch, expected %0d, actual %0d",
						$time, exp_res.slot, slot);
				end
				if (status !== exp_res.status) begin
					fail_count++;
					$display("%0t: status mismatch, expected %0d, actual %0d",
						$time, exp_res.status, status);
				end
			end
		end
		out_ready <= ($urandom_range(99) >= rcv_idle);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		table_res_t tr;
		int         ins_pct;
		foreach (slot_keys[i]) slot_keys[i] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int n = 0; n < NUM_DIRECTED; n++) begin
			tr.slot   = DIR_ROWS[n].slot;
			tr.status = DIR_ROWS[n].status;
			issue_request(DIR_ROWS[n].kind, DIR_ROWS[n].key, DIR_ROWS[n].typed, tr);
		end

		tr = '0;
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph != 0) hold_until_drained();
			snd_idle = SND_IDLE[ph];
			rcv_idle = RCV_IDLE[ph];
			for (int n = 0; n < RAND_PER_PHASE; n++) begin
				// drain and refill stretches so the table swings between empty and full
				ins_pct = ((n / 50) % 2 == 0) ? 25 : 75;
				issue_request(pick_kind(ins_pct), pick_key(), 1'b0, tr);
			end
		end

		hold_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
